// ----- rtl/core/bcc_pkg.sv -----
// Shared types, codes and arithmetic helpers for the barometer compensation core.
package bcc_pkg;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    localparam logic [2:0] REG_AC123  = 3'd0;
    localparam logic [2:0] REG_AC456  = 3'd1;
    localparam logic [2:0] REG_B12    = 3'd2;
    localparam logic [2:0] REG_MCMD   = 3'd3;
    localparam logic [2:0] REG_OSS    = 3'd4;

    localparam int          CFG_W     = 48;
    localparam logic signed [31:0] TEMP_MIN = -32'sd400;
    localparam logic signed [31:0] TEMP_MAX = 32'sd850;
    localparam logic signed [31:0] PRES_MAX = 32'sd131071;

    // Signed divide by 2^k, truncating toward zero.
    function automatic logic signed [31:0] f_tdiv(input logic signed [31:0] a, input int k);
        logic [31:0] mask;
        mask = (32'h1 << k) - 32'h1;
        return (a + (a[31] ? $signed(mask) : 32'sd0)) >>> k;
    endfunction

    function automatic logic signed [31:0] f_sx16(input logic [15:0] v);
        return $signed({{16{v[15]}}, v});
    endfunction

    function automatic logic [31:0] f_abs(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

endpackage

// ----- rtl/core/bcc_div.sv -----
// Pipelined restoring divider, unsigned, one quotient bit per stage, with sideband.
module bcc_div
    import bcc_pkg::*;
#(
    parameter int W  = 32,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_quo,
    output logic [PW-1:0] o_side
);

    logic [W-1:0]  r_rem  [W];
    logic [W-1:0]  r_quo  [W];
    logic [W-1:0]  r_den  [W];
    logic [PW-1:0] r_side [W];
    logic [W-1:0]  r_vld;

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic [W-1:0]  rem_in, quo_in, den_in, n_rem, n_quo;
        logic [PW-1:0] side_in;
        logic          vld_in;
        logic [W:0]    trial;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign quo_in  = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign quo_in  = r_quo[s-1];
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        always_comb begin
            trial = {rem_in, quo_in[W-1]} - {1'b0, den_in};
            if (!trial[W]) begin
                n_rem = trial[W-1:0];
                n_quo = {quo_in[W-2:0], 1'b1};
            end else begin
                n_rem = {rem_in[W-2:0], quo_in[W-1]};
                n_quo = {quo_in[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
            r_rem[s]  <= n_rem;
            r_quo[s]  <= n_quo;
            r_den[s]  <= den_in;
            r_side[s] <= side_in;
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_quo[W-1];
    assign o_side  = r_side[W-1];

endmodule

// ----- rtl/core/barometer_compensation_core.sv -----
// Top level: pipelined barometric temperature and pressure compensation.
//
// Usage:
//   Configuration: write the calibration words and the oversampling setting
//   through i_cfg_we / i_cfg_idx / i_cfg_data while no request is in flight.
//   Request: drive i_raw_temperature and i_raw_pressure_word with i_start
//   high for one cycle. o_busy is held low: a new request may enter every
//   cycle, so throughput is one request per clock.
//   Result: o_done pulses for one cycle with temperature (0.1 degC), pressure
//   (Pa) and status. Results leave in request order.
//   Pipeline: the two 32-stage dividers (temperature correction and pressure
//   quotient) make up most of the depth; the rest is multiply/scale stages.
//   Reset: synchronous, active low. Clears all pipeline valid bits, loads the
//   calibration words with zero and oversampling with one. Requests in
//   flight are dropped.
//   The receiver cannot stall; every result is presented exactly once.
module barometer_compensation_core
    import bcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [15:0]         i_raw_temperature,
    input  logic [23:0]         i_raw_pressure_word,
    output logic                o_done,
    output logic signed [10:0]  o_temperature_tenths,
    output logic [16:0]         o_pressure_pa,
    output logic [1:0]          o_status
);

    // ---------------- configuration ----------------
    logic [47:0] r_ac123, r_ac456;
    logic [31:0] r_b12, r_mcmd;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac123 <= '0;
            r_ac456 <= '0;
            r_b12   <= '0;
            r_mcmd  <= '0;
            r_oss   <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AC123: r_ac123 <= i_cfg_data[47:0];
                REG_AC456: r_ac456 <= i_cfg_data[47:0];
                REG_B12:   r_b12   <= i_cfg_data[31:0];
                REG_MCMD:  r_mcmd  <= i_cfg_data[31:0];
                REG_OSS:   r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // The user must keep the coefficients static while requests are in flight;
    // the block does not enforce this. Every stage reads them directly.
    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac5, ac6;
    logic [31:0]        ac4;
    logic [31:0]        oss_scale;
    assign ac1 = f_sx16(r_ac123[47:32]);
    assign ac2 = f_sx16(r_ac123[31:16]);
    assign ac3 = f_sx16(r_ac123[15:0]);
    assign ac4 = {16'h0, r_ac456[47:32]};
    assign ac5 = $signed({16'h0, r_ac456[31:16]});
    assign ac6 = $signed({16'h0, r_ac456[15:0]});
    assign b1  = f_sx16(r_b12[31:16]);
    assign b2  = f_sx16(r_b12[15:0]);
    assign mc  = f_sx16(r_mcmd[31:16]);
    assign md  = f_sx16(r_mcmd[15:0]);
    assign oss_scale = 32'd50000 >> r_oss;

    assign o_busy = 1'b0;

    // ---------------- temperature front end ----------------
    logic               r_s0_vld, r_s1_vld, r_s2_vld;
    logic [15:0]        r_s0_ut;
    logic [23:0]        r_s0_raw, r_s1_raw, r_s2_raw;
    logic signed [31:0] r_s1_d, r_s2_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s0_vld <= i_start & ~o_busy;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
        r_s0_ut  <= i_raw_temperature;
        r_s0_raw <= i_raw_pressure_word;
        r_s1_d   <= $signed({16'h0, r_s0_ut}) - ac6;
        r_s1_raw <= r_s0_raw;
        r_s2_m   <= r_s1_d * ac5;
        r_s2_raw <= r_s1_raw;
    end

    // X2 = (MC*2048) / (X1+MD), signed truncating, via magnitudes.
    logic signed [31:0] x1_t, den1, num1;
    logic [57:0]        side1_in, side1_out;
    logic [31:0]        quo1;
    logic               vld1;
    assign x1_t     = f_tdiv(r_s2_m, 15);
    assign den1     = x1_t + md;
    assign num1     = mc <<< 11;
    assign side1_in = {x1_t, r_s2_raw, num1[31] ^ den1[31], den1 == 32'sd0};

    bcc_div #(.W(32), .PW(58)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_vld),
        .i_num   (f_abs(num1)),
        .i_den   (f_abs(den1)),
        .i_side  (side1_in),
        .o_valid (vld1),
        .o_quo   (quo1),
        .o_side  (side1_out)
    );

    // ---------------- pressure polynomial stages ----------------
    logic               r_d1_vld;
    logic signed [31:0] r_d1_b5;
    logic [23:0]        r_d1_raw;
    logic               r_d1_dz;
    logic signed [31:0] x2_t;

    assign x2_t = side1_out[0] ? 32'sd0 :
                  (side1_out[1] ? -$signed(quo1) : $signed(quo1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d1_vld <= 1'b0;
        else          r_d1_vld <= vld1;
        r_d1_b5  <= $signed(side1_out[57:26]) + x2_t;
        r_d1_raw <= side1_out[25:2];
        r_d1_dz  <= side1_out[0];
    end

    // Temperature done here: clamp and carry it alongside.
    logic signed [31:0] t_full;
    logic               t_sat;
    logic signed [10:0] t_clamp;
    assign t_full  = f_tdiv(r_d1_b5 + 32'sd8, 4);
    assign t_sat   = (t_full < TEMP_MIN) || (t_full > TEMP_MAX);
    assign t_clamp = (t_full < TEMP_MIN) ? TEMP_MIN[10:0] :
                     (t_full > TEMP_MAX) ? TEMP_MAX[10:0] : t_full[10:0];

    typedef struct packed {
        logic signed [10:0] t;
        logic               sat;
        logic               dz;
        logic [23:0]        raw;
    } t_carry;

    logic               r_t_vld, r_m1_vld, r_c1_vld, r_m2_vld, r_c2_vld, r_c3_vld;
    logic               r_c4_vld, r_c5_vld;
    t_carry             r_t_c, r_m1_c, r_c1_c, r_m2_c, r_c2_c, r_c3_c, r_c4_c, r_c5_c;
    logic signed [31:0] r_t_b6;
    logic signed [31:0] r_m1_sq, r_m1_a2, r_m1_a3;
    logic signed [31:0] r_c1_sq, r_c1_x2, r_c1_x1;
    logic signed [31:0] r_m2_b2, r_m2_b1, r_m2_x2, r_m2_x1;
    logic signed [31:0] r_c2_b3p, r_c2_x3;
    logic signed [31:0] r_c3_b3;
    logic [31:0]        r_c3_b4p, r_c4_b4, r_c4_diff, r_c5_b4, r_c5_b7;
    logic signed [31:0] x3_p, x3_c;
    logic [31:0]        up;

    assign x3_p = f_tdiv(r_m2_b2, 11) + r_m2_x2;
    assign x3_c = f_tdiv(r_m2_x1 + f_tdiv(r_m2_b1, 16) + 32'sd2, 2);
    assign up   = {8'h0, r_c3_c.raw} >> (4'd8 - {2'b0, r_oss});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld  <= 1'b0;
            r_m1_vld <= 1'b0;
            r_c1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_c2_vld <= 1'b0;
            r_c3_vld <= 1'b0;
            r_c4_vld <= 1'b0;
            r_c5_vld <= 1'b0;
        end else begin
            r_t_vld  <= r_d1_vld;
            r_m1_vld <= r_t_vld;
            r_c1_vld <= r_m1_vld;
            r_m2_vld <= r_c1_vld;
            r_c2_vld <= r_m2_vld;
            r_c3_vld <= r_c2_vld;
            r_c4_vld <= r_c3_vld;
            r_c5_vld <= r_c4_vld;
        end
        r_t_c    <= '{t: t_clamp, sat: t_sat, dz: r_d1_dz, raw: r_d1_raw};
        r_t_b6   <= r_d1_b5 - 32'sd4000;
        // B6 products
        r_m1_c   <= r_t_c;
        r_m1_sq  <= r_t_b6 * r_t_b6;
        r_m1_a2  <= ac2 * r_t_b6;
        r_m1_a3  <= ac3 * r_t_b6;
        r_c1_c   <= r_m1_c;
        r_c1_sq  <= f_tdiv(r_m1_sq, 12);
        r_c1_x2  <= f_tdiv(r_m1_a2, 11);
        r_c1_x1  <= f_tdiv(r_m1_a3, 13);
        r_m2_c   <= r_c1_c;
        r_m2_b2  <= b2 * r_c1_sq;
        r_m2_b1  <= b1 * r_c1_sq;
        r_m2_x2  <= r_c1_x2;
        r_m2_x1  <= r_c1_x1;
        // B3 before rounding, X3 for B4
        r_c2_c   <= r_m2_c;
        r_c2_b3p <= ((ac1 <<< 2) + x3_p) <<< r_oss;
        r_c2_x3  <= x3_c;
        r_c3_c   <= r_c2_c;
        r_c3_b3  <= f_tdiv(r_c2_b3p + 32'sd2, 2);
        r_c3_b4p <= ac4 * (32'(r_c2_x3) + 32'd32768);
        r_c4_c   <= r_c3_c;
        r_c4_b4  <= r_c3_b4p >> 15;
        r_c4_diff <= up - 32'(r_c3_b3);
        r_c5_c   <= r_c4_c;
        r_c5_b4  <= r_c4_b4;
        r_c5_b7  <= r_c4_diff * oss_scale;
    end

    // P = B7*2/B4, or (B7/B4)*2 when B7 has its top bit set.
    logic        b7_hi, vld2;
    logic [31:0] num2, quo2;
    logic [14:0] side2_in, side2_out;
    assign b7_hi    = r_c5_b7[31];
    assign num2     = b7_hi ? r_c5_b7 : {r_c5_b7[30:0], 1'b0};
    assign side2_in = {r_c5_c.t, r_c5_c.sat, r_c5_c.dz, b7_hi, r_c5_b4 == 32'h0};

    bcc_div #(.W(32), .PW(15)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c5_vld),
        .i_num   (num2),
        .i_den   (r_c5_b4),
        .i_side  (side2_in),
        .o_valid (vld2),
        .o_quo   (quo2),
        .o_side  (side2_out)
    );

    // ---------------- pressure correction ----------------
    typedef struct packed {
        logic signed [10:0] t;
        logic               sat;
        logic               dz;
    } t_tail;

    logic               r_p_vld, r_q1_vld, r_q2_vld, r_q3_vld, r_q4_vld;
    t_tail              r_p_c, r_q1_c, r_q2_c, r_q3_c, r_q4_c;
    logic signed [31:0] r_p_p, r_q1_p, r_q1_x1, r_q1_pm, r_q2_p, r_q2_sq, r_q2_pm;
    logic signed [31:0] r_q3_p, r_q3_m, r_q3_pm, r_q4_p;
    logic signed [31:0] p_corr;

    assign p_corr = r_q3_p + f_tdiv(f_tdiv(r_q3_m, 16) + f_tdiv(r_q3_pm, 16)
                                    + 32'sd3791, 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_q1_vld <= 1'b0;
            r_q2_vld <= 1'b0;
            r_q3_vld <= 1'b0;
            r_q4_vld <= 1'b0;
        end else begin
            r_p_vld  <= vld2;
            r_q1_vld <= r_p_vld;
            r_q2_vld <= r_q1_vld;
            r_q3_vld <= r_q2_vld;
            r_q4_vld <= r_q3_vld;
        end
        r_p_c   <= '{t: side2_out[14:4], sat: side2_out[3],
                     dz: side2_out[2] | side2_out[0]};
        r_p_p   <= side2_out[0] ? 32'sd0 :
                   $signed(side2_out[1] ? {quo2[30:0], 1'b0} : quo2);
        r_q1_c  <= r_p_c;
        r_q1_p  <= r_p_p;
        r_q1_x1 <= f_tdiv(r_p_p, 8);
        r_q1_pm <= -32'sd7357 * r_p_p;
        r_q2_c  <= r_q1_c;
        r_q2_p  <= r_q1_p;
        r_q2_sq <= r_q1_x1 * r_q1_x1;
        r_q2_pm <= r_q1_pm;
        r_q3_c  <= r_q2_c;
        r_q3_p  <= r_q2_p;
        r_q3_m  <= r_q2_sq * 32'sd3038;
        r_q3_pm <= r_q2_pm;
        r_q4_c  <= r_q3_c;
        r_q4_p  <= p_corr;
    end

    // ---------------- output register ----------------
    logic p_sat;
    assign p_sat = r_q4_p[31] || (r_q4_p > PRES_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_q4_vld;
        end
        o_temperature_tenths <= r_q4_c.t;
        o_pressure_pa <= r_q4_p[31] ? 17'h0 :
                         (r_q4_p > PRES_MAX) ? PRES_MAX[16:0] : r_q4_p[16:0];
        if (r_q4_c.dz)
            o_status <= ST_DIV0;
        else if (r_q4_c.sat || p_sat)
            o_status <= ST_SAT;
        else
            o_status <= ST_OK;
    end

    // ---------------- assertions ----------------
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_temperature_tenths >= -11'sd400 && o_temperature_tenths <= 11'sd850))
        else $error("temperature outside clamp range");
    a_dz_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q4_vld && r_q4_c.dz |=> o_done && o_status == ST_DIV0)
        else $error("zero divisor not reported");
    a_busy_low: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised on a fully pipelined core");

endmodule
